// ----- rtl/modular_exponentiation_engine_assert.svh -----
// Assertion macros for the modular exponentiation engine.
// Included by RTL modules that carry concurrent checks; no other dependencies.
`ifndef MODULAR_EXPONENTIATION_ENGINE_ASSERT_SVH
`define MODULAR_EXPONENTIATION_ENGINE_ASSERT_SVH

`ifndef SYNTHESIS

// Same-cycle implication, disabled while reset is asserted
`define MEE_ASSERT_IMPL(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted
`define MEE_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define MEE_ASSERT_IMPL(label, clk, rstn, ante, cons)
`define MEE_ASSERT_NEXT(label, clk, rstn, ante, cons)

`endif

`endif

// ----- rtl/mee_pkg.sv -----
// Package for the modular exponentiation engine: widths, modulus constants
// and the Barrett correction function. No dependencies.
package mee_pkg;

    localparam int RES_W   = 30;
    localparam int BASE_W  = 30;
    localparam int EXP_W   = 31;
    localparam int MUL_W   = 31;
    localparam int MULP_W  = 2 * MUL_W;
    localparam int PROD_W  = 2 * RES_W;
    localparam int DIFF_W  = 32;

    // Prime modulus and the fixed exponent used for the inverse
    localparam logic [RES_W-1:0] MODULUS = 30'd1000000007;
    localparam logic [EXP_W-1:0] INV_EXP = 31'd1000000005;

    // Barrett constant floor(2^60 / MODULUS)
    localparam logic [MUL_W-1:0] BARRETT_MU = 31'd1152921496;

    localparam logic [DIFF_W-1:0] MOD_D   = 32'd1000000007;
    localparam logic [DIFF_W-1:0] TWO_M   = 32'd2000000014;
    localparam logic [DIFF_W-1:0] THREE_M = 32'd3000000021;

    // Bring a Barrett remainder in [0, 3M) down to [0, M)
    function automatic logic [RES_W-1:0] mod_fix(input logic [DIFF_W-1:0] r);
        logic [DIFF_W-1:0] t;
        if (r >= TWO_M) begin
            t = r - TWO_M;
        end else if (r >= MOD_D) begin
            t = r - MOD_D;
        end else begin
            t = r;
        end
        return t[RES_W-1:0];
    endfunction

endpackage

// ----- rtl/modular_exponentiation_engine.sv -----
// Modular exponentiation engine, top level: square-and-multiply over one
// shared 31x31 multiplier with Barrett reduction. Depends on mee_pkg and
// modular_exponentiation_engine_assert.svh.
//
//  channel  | ports                                   | direction
//  ---------+-----------------------------------------+----------
//  input    | s_valid s_ready s_operation s_base s_exponent | in
//  result   | m_valid m_ready m_residue               | out
//
// Each exponent bit passes through the states MUL_A, MUL_B, EST_A, EST_B,
// RED_A, RED_B and FIX_B; a zero exponent goes straight to DONE. With the
// single multiplier, each bit needs three multiplies for the running product
// and three for the square, plus one correction step.
// The result sits in an output register, so a new word is taken while it waits.
// Reset (aresetn, synchronous, active low) clears the sequencer and m_valid.
`include "modular_exponentiation_engine_assert.svh"

module modular_exponentiation_engine
    import mee_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic              s_operation,
    input  logic [BASE_W-1:0] s_base,
    input  logic [EXP_W-1:0]  s_exponent,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [RES_W-1:0]  m_residue
);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL_A,
        ST_MUL_B,
        ST_EST_A,
        ST_EST_B,
        ST_RED_A,
        ST_RED_B,
        ST_FIX_B,
        ST_DONE
    } state_t;

    state_t             state_reg, state_next;
    logic               m_valid_reg, m_valid_next;
    logic [RES_W-1:0]   res_reg, res_next;

    logic [RES_W-1:0]   acc_reg, acc_next;
    logic [RES_W-1:0]   sq_reg, sq_next;
    logic [EXP_W-1:0]   e_reg, e_next;
    logic [PROD_W-1:0]  pa_reg, pa_next;
    logic [PROD_W-1:0]  pb_reg, pb_next;
    logic [RES_W-1:0]   qa_reg, qa_next;
    logic [RES_W-1:0]   qb_reg, qb_next;
    logic [DIFF_W-1:0]  qma_reg, qma_next;
    logic [DIFF_W-1:0]  qmb_reg, qmb_next;

    logic [MUL_W-1:0]   mul_x, mul_y;
    logic [MULP_W-1:0]  mul_p;
    logic [DIFF_W-1:0]  diff_a, diff_b;
    logic [RES_W-1:0]   base_red;
    logic [EXP_W-1:0]   exp_sel;
    logic               s_accept;

    assign s_ready  = (state_reg == ST_IDLE);
    assign s_accept = s_valid && s_ready;
    assign m_valid  = m_valid_reg;
    assign m_residue = res_reg;

    // Reduce an out-of-range base once at acceptance
    assign base_red = (s_base >= MODULUS) ? (s_base - MODULUS) : s_base;
    assign exp_sel  = s_operation ? INV_EXP : s_exponent;

    // Barrett remainders, exact modulo 2^32 since they stay below 3M
    assign diff_a = pa_reg[DIFF_W-1:0] - qma_reg;
    assign diff_b = pb_reg[DIFF_W-1:0] - qmb_reg;

    // Route operands into the shared multiplier
    always_comb begin
        case (state_reg)
            ST_MUL_A: begin
                mul_x = {1'b0, acc_reg};
                mul_y = {1'b0, sq_reg};
            end
            ST_MUL_B: begin
                mul_x = {1'b0, sq_reg};
                mul_y = {1'b0, sq_reg};
            end
            ST_EST_A: begin
                mul_x = pa_reg[PROD_W-1:RES_W-1];
                mul_y = BARRETT_MU;
            end
            ST_EST_B: begin
                mul_x = pb_reg[PROD_W-1:RES_W-1];
                mul_y = BARRETT_MU;
            end
            ST_RED_A: begin
                mul_x = {1'b0, qa_reg};
                mul_y = {1'b0, MODULUS};
            end
            ST_RED_B: begin
                mul_x = {1'b0, qb_reg};
                mul_y = {1'b0, MODULUS};
            end
            default: begin
                mul_x = '0;
                mul_y = '0;
            end
        endcase
    end

    assign mul_p = MULP_W'(mul_x) * MULP_W'(mul_y);

    // Sequencer and datapath next values
    always_comb begin
        state_next   = state_reg;
        m_valid_next = m_valid_reg;
        res_next     = res_reg;
        acc_next     = acc_reg;
        sq_next      = sq_reg;
        e_next       = e_reg;
        pa_next      = pa_reg;
        pb_next      = pb_reg;
        qa_next      = qa_reg;
        qb_next      = qb_reg;
        qma_next     = qma_reg;
        qmb_next     = qmb_reg;

        // Drop the result word once taken
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    acc_next   = RES_W'(1);
                    sq_next    = base_red;
                    e_next     = exp_sel;
                    state_next = (exp_sel == '0) ? ST_DONE : ST_MUL_A;
                end
            end
            ST_MUL_A: begin
                pa_next    = mul_p[PROD_W-1:0];
                state_next = ST_MUL_B;
            end
            ST_MUL_B: begin
                pb_next    = mul_p[PROD_W-1:0];
                state_next = ST_EST_A;
            end
            ST_EST_A: begin
                qa_next    = mul_p[2*RES_W:RES_W+1];
                state_next = ST_EST_B;
            end
            ST_EST_B: begin
                qb_next    = mul_p[2*RES_W:RES_W+1];
                state_next = ST_RED_A;
            end
            ST_RED_A: begin
                qma_next   = mul_p[DIFF_W-1:0];
                state_next = ST_RED_B;
            end
            ST_RED_B: begin
                qmb_next   = mul_p[DIFF_W-1:0];
                // Fold the square into the running product when the bit is set
                if (e_reg[0]) begin
                    acc_next = mod_fix(diff_a);
                end
                state_next = ST_FIX_B;
            end
            ST_FIX_B: begin
                sq_next    = mod_fix(diff_b);
                e_next     = e_reg >> 1;
                state_next = ((e_reg >> 1) == '0) ? ST_DONE : ST_MUL_A;
            end
            ST_DONE: begin
                // Hold until the output register is free
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    res_next     = acc_reg;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Sequencer state and registered outputs
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
        res_reg <= res_next;
    end

    // Datapath registers
    always_ff @(posedge aclk) begin
        acc_reg <= acc_next;
        sq_reg  <= sq_next;
        e_reg   <= e_next;
        pa_reg  <= pa_next;
        pb_reg  <= pb_next;
        qa_reg  <= qa_next;
        qb_reg  <= qb_next;
        qma_reg <= qma_next;
        qmb_reg <= qmb_next;
    end

    // Operands stay reduced throughout the loop
    `MEE_ASSERT_IMPL(a_operands_reduced, aclk, aresetn, state_reg != ST_IDLE, (acc_reg < MODULUS) && (sq_reg < MODULUS))
    // A bit is only processed while exponent bits remain
    `MEE_ASSERT_IMPL(a_exp_nonzero, aclk, aresetn, state_reg == ST_MUL_A, e_reg != '0)
    // Barrett remainders stay inside the correction range
    `MEE_ASSERT_IMPL(a_barrett_a, aclk, aresetn, state_reg == ST_RED_B, diff_a < THREE_M)
    `MEE_ASSERT_IMPL(a_barrett_b, aclk, aresetn, state_reg == ST_FIX_B, diff_b < THREE_M)
    // A result leaving the loop presents a word on the next cycle
    `MEE_ASSERT_NEXT(a_done_out, aclk, aresetn, (state_reg == ST_DONE) && (!m_valid_reg || m_ready), m_valid_reg && (res_reg < MODULUS))

endmodule

// ----- tb/sv/tb_top.sv -----
// Self-checking bench for modular_exponentiation_engine: directed and random words,
// with idling on both channels and a long result hold-off. Predicts each residue itself.
// Depends on mee_pkg and the engine RTL only.
module tb_top
    import mee_pkg::*;
();

    localparam int unsigned CYCLE_LIMIT  = 2_000_000;
    localparam int unsigned HOLD_LEN     = 1500;
    localparam int unsigned DRAIN_CYCLES = 250;
    localparam int unsigned RANDOM_WORDS = 1700;
    localparam int unsigned PHASES       = 4;
    localparam int unsigned PRESSURE_WORDS = 16;

    localparam logic OP_POWER   = 1'b0;
    localparam logic OP_INVERSE = 1'b1;

    localparam logic [BASE_W-1:0] BASE_TOP = {BASE_W{1'b1}};
    localparam logic [EXP_W-1:0]  EXP_TOP  = {EXP_W{1'b1}};

    // Keeps the residues still owed by the engine, oldest first
    class modpow_tracker;
        logic [RES_W-1:0] residues_due[$];
        int unsigned      mismatches;

        function new();
            mismatches = 0;
        endfunction

        // Right-to-left square-and-multiply, every product reduced
        function logic [RES_W-1:0] power_mod(logic op, logic [BASE_W-1:0] b,
                                             logic [EXP_W-1:0] e);
            longint unsigned m;
            longint unsigned sq;
            longint unsigned acc;
            longint unsigned ex;
            m   = 64'(MODULUS);
            sq  = 64'(b);
            sq  = sq % m;
            acc = 64'(1);
            ex  = (op == OP_INVERSE) ? 64'(INV_EXP) : 64'(e);
            while (ex != 0) begin
                if ((ex & 1) != 0) begin
                    acc = (acc * sq) % m;
                end
                sq = (sq * sq) % m;
                ex = ex >> 1;
            end
            return acc[RES_W-1:0];
        endfunction

        function void note_request(logic op, logic [BASE_W-1:0] b, logic [EXP_W-1:0] e);
            residues_due.push_back(power_mod(op, b, e));
        endfunction

        function void check_residue(logic [RES_W-1:0] actual);
            logic [RES_W-1:0] want;
            if (residues_due.size() == 0) begin
                $display("%0t: residue %0d arrived with none outstanding", $time, actual);
                mismatches++;
            end else begin
                want = residues_due.pop_front();
                if (actual !== want) begin
                    $display("%0t: residue mismatch, wanted %0d, got %0d",
                             $time, want, actual);
                    mismatches++;
                end
            end
        endfunction
    endclass

    logic              aclk        = 1'b0;
    logic              aresetn     = 1'b0;
    logic              s_valid     = 1'b0;
    logic              s_operation = 1'b0;
    logic [BASE_W-1:0] s_base      = '0;
    logic [EXP_W-1:0]  s_exponent  = '0;
    logic              m_ready     = 1'b0;
    logic              s_ready;
    logic              m_valid;
    logic [RES_W-1:0]  m_residue;

    int unsigned src_idle_pct   = 0;
    int unsigned sink_stall_pct = 0;
    int unsigned hold_req       = 0;
    longint unsigned cycle_count = 0;

    modpow_tracker tracker = new();

    modular_exponentiation_engine u_top (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_operation (s_operation),
        .s_base      (s_base),
        .s_exponent  (s_exponent),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_residue   (m_residue)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // Abandon the run if it overstays the limit
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    // Record accepted words and check returned residues
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) begin
                tracker.note_request(s_operation, s_base, s_exponent);
            end
            if (m_valid && m_ready) begin
                tracker.check_residue(m_residue);
            end
        end
    end

    // Drive m_ready: random stalls, plus a long hold-off on request
    initial begin : result_sink
        int unsigned hold_left;
        int unsigned hold_seen;
        hold_left = 0;
        hold_seen = 0;
        forever begin
            @(posedge aclk);
            if (hold_req != hold_seen) begin
                hold_seen = hold_req;
                hold_left = HOLD_LEN;
            end
            if (!aresetn) begin
                m_ready <= 1'b0;
            end else if (hold_left != 0) begin
                m_ready <= 1'b0;
                hold_left--;
            end else begin
                m_ready <= ($urandom_range(99) >= sink_stall_pct);
            end
        end
    end

    // Offer one word, idling first at random, and hold it until taken
    task automatic send_word(input logic op, input logic [BASE_W-1:0] b,
                             input logic [EXP_W-1:0] e);
        while ($urandom_range(99) < src_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_operation <= op;
        s_base      <= b;
        s_exponent  <= e;
        @(posedge aclk);
        while (!s_ready) begin
            @(posedge aclk);
        end
    endtask

    // Random word: mostly in-range bases, exponents of random bit length
    task automatic random_word();
        logic              op;
        logic [BASE_W-1:0] b;
        logic [EXP_W-1:0]  e;
        int unsigned       pick;
        int unsigned       bits;
        op   = ($urandom_range(3) == 0) ? OP_INVERSE : OP_POWER;
        pick = $urandom_range(19);
        if (pick == 0) begin
            b = BASE_W'($urandom_range(3));
        end else if (pick == 1) begin
            b = BASE_W'($urandom_range(BASE_TOP, MODULUS));
        end else begin
            b = BASE_W'($urandom_range(MODULUS - 1));
        end
        bits = $urandom_range(EXP_W);
        if (bits == 0) begin
            e = $urandom_range(3) == 0 ? EXP_W'($urandom) : '0;
            if (op == OP_POWER) begin
                e = '0;
            end
        end else begin
            e = EXP_W'($urandom) & (EXP_TOP >> (EXP_W - bits));
            e[bits-1] = 1'b1;
        end
        send_word(op, b, e);
    endtask

    initial begin : stimulus
        int unsigned phase_idle_src[PHASES];
        int unsigned phase_idle_sink[PHASES];
        phase_idle_src  = '{0, 45, 0, 37};
        phase_idle_sink = '{0, 0, 45, 37};

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed words: field extremes, zero exponent, zero base, unreduced base
        send_word(OP_POWER,   '0,             '0);
        send_word(OP_POWER,   '0,             31'd5);
        send_word(OP_POWER,   MODULUS - 30'd1, '0);
        send_word(OP_POWER,   MODULUS - 30'd1, EXP_TOP);
        send_word(OP_POWER,   BASE_TOP,       EXP_TOP);
        send_word(OP_POWER,   BASE_TOP,       '0);
        send_word(OP_POWER,   MODULUS,        '0);
        send_word(OP_POWER,   MODULUS,        31'd3);
        send_word(OP_POWER,   30'd2,          31'd30);
        send_word(OP_POWER,   30'd12345,      31'd1);
        send_word(OP_POWER,   30'd12345,      31'd2);
        send_word(OP_POWER,   30'h2AAA_AAAA,  31'h5555_5555);
        send_word(OP_POWER,   30'h1555_5555,  31'h2AAA_AAAA);
        send_word(OP_POWER,   30'd1,          EXP_TOP);
        send_word(OP_INVERSE, '0,             '0);
        send_word(OP_INVERSE, '0,             EXP_TOP);
        send_word(OP_INVERSE, 30'd1,          31'd7);
        send_word(OP_INVERSE, 30'd2,          '0);
        send_word(OP_INVERSE, MODULUS - 30'd1, EXP_TOP);
        send_word(OP_INVERSE, MODULUS,        '0);
        send_word(OP_INVERSE, BASE_TOP,       31'h5555_5555);
        send_word(OP_INVERSE, 30'd500000004,  31'h2AAA_AAAA);

        // Random phases, each with its own idling mix
        for (int unsigned p = 0; p < PHASES; p++) begin
            src_idle_pct   <= phase_idle_src[p];
            sink_stall_pct <= phase_idle_sink[p];
            for (int unsigned n = 0; n < RANDOM_WORDS / PHASES; n++) begin
                random_word();
            end
            // Hold results off for a long stretch while words keep coming
            if (p == 1) begin
                src_idle_pct <= 0;
                hold_req     <= hold_req + 1;
                for (int unsigned n = 0; n < PRESSURE_WORDS; n++) begin
                    random_word();
                end
            end
        end
        s_valid <= 1'b0;
        // Let the monitor note the last accepted word first
        @(posedge aclk);

        // Drain outstanding residues, then allow for stray words
        while (tracker.residues_due.size() != 0) begin
            @(posedge aclk);
        end
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (tracker.mismatches == 0 && tracker.residues_due.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
